// ===== sv/bit_run_nibble_encoder_core_defines.svh =====
// assertion macros used by the encoder engine rtl
`ifndef BIT_RUN_NIBBLE_ENCODER_CORE_DEFINES_SVH
`define BIT_RUN_NIBBLE_ENCODER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BRNE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define BRNE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/brne_pkg.sv =====
package brne_pkg;

	// field widths
	localparam int DATA_W = 8;
	localparam int RUN_W  = 6;
	localparam int NIB_W  = 4;
	localparam int CNT_W  = 3;

	// queue depths, powers of two so pointers wrap on their own
	localparam int IN_DEPTH  = 2;
	localparam int IN_AW     = $clog2(IN_DEPTH);
	localparam int IN_CW     = $clog2(IN_DEPTH + 1);
	localparam int OUT_DEPTH = 4;
	localparam int OUT_AW    = $clog2(OUT_DEPTH);
	localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

	// chunk limits
	localparam logic [RUN_W-1:0] MAX_CHUNK   = 6'd63;
	localparam logic [RUN_W-1:0] SHORT_MAX   = 6'd3;
	localparam logic [CNT_W-1:0] BIT_CNT_END = 3'd7;

	// one queued input transaction
	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              last;
	} brne_item_t;

	// one output transaction
	typedef struct packed {
		logic [DATA_W-1:0] code;
		logic              stream_end;
	} brne_result_t;

	// nibble codes for one chunk
	typedef struct packed {
		logic             two;
		logic [NIB_W-1:0] n0;
		logic [NIB_W-1:0] n1;
	} brne_chunk_t;

	// short chunk: one nibble; long chunk: prefix nibble then low four count bits
	function automatic brne_chunk_t chunk_code(input logic bitv, input logic [RUN_W-1:0] cnt);
		brne_chunk_t c;
		c.two = (cnt > SHORT_MAX);
		if (c.two) begin
			c.n0 = {bitv, 1'b1, cnt[5:4]};
		end else begin
			c.n0 = {bitv, 1'b0, cnt[1:0]};
		end
		c.n1 = cnt[3:0];
		return c;
	endfunction

endpackage

// ===== sv/bit_run_nibble_encoder_core.sv =====
// a byte taken into an empty block passes the input queue, the run engine and the output queue
// the run engine takes one bit per cycle while the output queue is not full
// a final byte also runs the flush step, and the pad step if a nibble is held, then idles
// results leave at most one per cycle through a 4-entry output queue
// reset: arst_n clears both queues, the sequencer and the run state (zeros counted first)
module bit_run_nibble_encoder_core import brne_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] code_byte,
	output logic       stream_end
);

	logic         item_valid;
	brne_item_t   item;
	logic         item_pop;
	logic         out_full;
	logic         res_valid;
	brne_result_t res;

	// input side queue
	brne_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.full       (full),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	// bit-serial run encoder
	brne_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.out_full   (out_full),
		.res_valid  (res_valid),
		.res        (res)
	);

	// result side queue
	brne_out_q u_out_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid),
		.res        (res),
		.out_full   (out_full),
		.empty      (empty),
		.pop        (pop),
		.code_byte  (code_byte),
		.stream_end (stream_end)
	);

endmodule

// ===== sv/brne_front.sv =====
module brne_front import brne_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       full,
	output logic       item_valid,
	output brne_item_t item,
	input  logic       item_pop
);

	brne_item_t       mem_q [IN_DEPTH];
	logic [IN_AW-1:0] wr_ptr_q;
	logic [IN_AW-1:0] rd_ptr_q;
	logic [IN_CW-1:0] count_q;
	logic             wr_en;
	logic             rd_en;
	brne_item_t       wr_item;

	// classify the incoming byte into a queue entry
	always_comb begin
		wr_item.data = data_byte;
		wr_item.last = final_byte;
	end

	assign full       = (count_q == IN_CW'(IN_DEPTH));
	assign item_valid = (count_q != '0);
	assign item       = mem_q[rd_ptr_q];
	assign wr_en      = push && !full;
	assign rd_en      = item_pop && item_valid;

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// ===== sv/brne_out_q.sv =====
module brne_out_q import brne_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         res_valid,
	input  brne_result_t res,
	output logic         out_full,
	output logic         empty,
	input  logic         pop,
	output logic [7:0]   code_byte,
	output logic         stream_end
);

	brne_result_t      mem_q [OUT_DEPTH];
	logic [OUT_AW-1:0] wr_ptr_q;
	logic [OUT_AW-1:0] rd_ptr_q;
	logic [OUT_CW-1:0] count_q;
	logic              wr_en;
	logic              rd_en;
	brne_result_t      head;

	assign out_full   = (count_q == OUT_CW'(OUT_DEPTH));
	assign empty      = (count_q == '0);
	assign wr_en      = res_valid && !out_full;
	assign rd_en      = pop && !empty;
	assign head       = mem_q[rd_ptr_q];
	assign code_byte  = head.code;
	assign stream_end = head.stream_end;

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// result storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= res;
		end
	end

endmodule

// ===== sv/brne_engine.sv =====
`include "bit_run_nibble_encoder_core_defines.svh"

module brne_engine import brne_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	input  brne_item_t   item,
	output logic         item_pop,
	input  logic         out_full,
	output logic         res_valid,
	output brne_result_t res
);

	typedef enum logic [1:0] {ST_IDLE, ST_BITS, ST_FLUSH, ST_PAD} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   bit_cnt_q;
	logic               run_bit_q;
	logic [RUN_W-1:0]   run_len_q;
	logic [NIB_W-1:0]   held_q;
	logic               waiting_q;
	logic [DATA_W-1:0]  data_q;
	logic               last_q;

	logic               adv;
	logic               cur_bit;
	logic               chunk_go;
	logic [RUN_W-1:0]   chunk_cnt;
	logic               chunk_bit;
	logic               nxt_run_bit;
	logic [RUN_W-1:0]   nxt_run_len;
	brne_chunk_t        code;
	logic               byte_go;
	logic [DATA_W-1:0]  byte_val;
	logic [NIB_W-1:0]   nxt_held;
	logic               nxt_wait;
	logic               load;
	logic               end_out;
	logic               run_idle;
	logic               first_bit;

	assign adv     = !out_full;
	assign cur_bit = data_q[DATA_W-1];

	// run tracking for the current bit, or the pending chunk on flush
	always_comb begin
		chunk_go    = 1'b0;
		chunk_cnt   = run_len_q;
		chunk_bit   = run_bit_q;
		nxt_run_bit = run_bit_q;
		nxt_run_len = run_len_q;
		case (state_q)
			ST_BITS: begin
				if (cur_bit == run_bit_q) begin
					if (run_len_q == MAX_CHUNK) begin
						chunk_go    = 1'b1;
						chunk_cnt   = MAX_CHUNK;
						nxt_run_len = RUN_W'(1);
					end else begin
						nxt_run_len = run_len_q + 1'b1;
					end
				end else begin
					chunk_go    = 1'b1;
					nxt_run_bit = !run_bit_q;
					nxt_run_len = RUN_W'(1);
				end
			end
			ST_FLUSH: begin
				chunk_go = 1'b1;
			end
			default: begin
				chunk_go = 1'b0;
			end
		endcase
	end

	assign code = chunk_code(chunk_bit, chunk_cnt);

	// nibble packing against the held half byte
	always_comb begin
		byte_go  = 1'b0;
		byte_val = {held_q, code.n0};
		nxt_held = held_q;
		nxt_wait = waiting_q;
		if (chunk_go) begin
			if (waiting_q) begin
				byte_go  = 1'b1;
				byte_val = {held_q, code.n0};
				nxt_held = code.n1;
				nxt_wait = code.two;
			end else if (code.two) begin
				byte_go  = 1'b1;
				byte_val = {code.n0, code.n1};
				nxt_wait = 1'b0;
			end else begin
				nxt_held = code.n0;
				nxt_wait = 1'b1;
			end
		end
	end

	// result to the output queue
	always_comb begin
		res_valid      = 1'b0;
		res.code       = byte_val;
		res.stream_end = 1'b0;
		case (state_q)
			ST_BITS: begin
				res_valid = adv && byte_go;
			end
			ST_FLUSH: begin
				res_valid      = adv && byte_go;
				res.stream_end = !nxt_wait;
			end
			ST_PAD: begin
				res_valid      = adv;
				res.code       = {held_q, NIB_W'(0)};
				res.stream_end = 1'b1;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// take the next byte when idle or on the last bit of a plain byte
	assign load = item_valid && ((state_q == ST_IDLE) ||
		(state_q == ST_BITS && adv && bit_cnt_q == BIT_CNT_END && !last_q));
	assign item_pop = load;

	// sequencer and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			run_bit_q <= 1'b0;
			run_len_q <= '0;
			held_q    <= '0;
			waiting_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (load) begin
						state_q   <= ST_BITS;
						bit_cnt_q <= '0;
					end
				end
				ST_BITS: begin
					if (adv) begin
						run_bit_q <= nxt_run_bit;
						run_len_q <= nxt_run_len;
						held_q    <= nxt_held;
						waiting_q <= nxt_wait;
						bit_cnt_q <= bit_cnt_q + 1'b1;
						if (bit_cnt_q == BIT_CNT_END) begin
							if (last_q) begin
								state_q <= ST_FLUSH;
							end else if (load) begin
								state_q <= ST_BITS;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_FLUSH: begin
					if (adv) begin
						if (nxt_wait) begin
							held_q    <= nxt_held;
							waiting_q <= 1'b1;
							state_q   <= ST_PAD;
						end else begin
							run_bit_q <= 1'b0;
							run_len_q <= '0;
							held_q    <= '0;
							waiting_q <= 1'b0;
							state_q   <= ST_IDLE;
						end
					end
				end
				ST_PAD: begin
					if (adv) begin
						run_bit_q <= 1'b0;
						run_len_q <= '0;
						held_q    <= '0;
						waiting_q <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// byte shifter, msb first
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= item.data;
			last_q <= item.last;
		end else if (state_q == ST_BITS && adv) begin
			data_q <= {data_q[DATA_W-2:0], 1'b0};
		end
	end

	// conditions watched by the checks
	assign end_out   = res_valid && res.stream_end;
	assign run_idle  = !waiting_q && (run_len_q == '0) && !run_bit_q;
	assign first_bit = (state_q == ST_BITS) && (bit_cnt_q == '0);

	// checks
	`BRNE_ASSERT_NOW(a_emit_room, clk, arst_n, res_valid, !out_full, "result written into a full queue")
	`BRNE_ASSERT_NOW(a_pad_half, clk, arst_n, state_q == ST_PAD, waiting_q, "pad without held nibble")
	`BRNE_ASSERT_NEXT(a_end_clears, clk, arst_n, end_out, run_idle, "run state kept after stream end")
	`BRNE_ASSERT_NEXT(a_load_starts, clk, arst_n, item_pop, first_bit, "loaded byte not at first bit")

endmodule

// ===== test/tb_bit_run_nibble_encoder_core.sv =====
module tb_bit_run_nibble_encoder_core import brne_pkg::*; ();

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_AFTER  = 150;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_AT    = 300;
	localparam int RANDOM_LEN  = 420;
	localparam int TAIL_ITEMS  = 50;
	localparam int SETTLE      = 24;
	localparam int MAX_REPORTS = 10;

	// content styles for random byte streams
	typedef enum int {
		STY_RANDOM,
		STY_LONG_RUN,
		STY_ALTERNATE,
		STY_SPARSE
	} stream_style_e;

	// one pending input transaction, optionally waiting for the block to drain
	typedef struct {
		logic [7:0] data;
		logic       last;
		bit         drain;
	} pending_byte_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       push       = 1'b0;
	logic [7:0] data_byte  = 8'h00;
	logic       final_byte = 1'b0;
	logic       pop        = 1'b0;
	logic       full;
	logic       empty;
	logic [7:0] code_byte;
	logic       stream_end;

	pending_byte_t byte_q[$];
	brne_result_t  code_q[$];

	// encoder state mirror
	logic       enc_bit  = 1'b0;
	logic [5:0] enc_len  = '0;
	logic [3:0] enc_held = '0;
	logic       enc_half = 1'b0;

	int cycles      = 0;
	int total_bytes = 0;
	int bytes_taken = 0;
	int mismatches  = 0;
	int gap_left    = 0;
	int stall_left  = 0;
	int hold_left   = 0;
	bit held_off    = 1'b0;

	bit_run_nibble_encoder_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.empty      (empty),
		.pop        (pop),
		.code_byte  (code_byte),
		.stream_end (stream_end)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// pack one nibble code, a byte leaves once two are held
	function automatic void pack_nibble(input logic [3:0] nib);
		brne_result_t r;
		if (enc_half) begin
			r.code       = {enc_held, nib};
			r.stream_end = 1'b0;
			code_q.push_back(r);
			enc_held = '0;
			enc_half = 1'b0;
		end else begin
			enc_held = nib;
			enc_half = 1'b1;
		end
	endfunction

	// short runs fit one nibble, longer ones take a prefix and the low count bits
	function automatic void pack_run(input logic [5:0] cnt);
		if (cnt <= 6'd3) begin
			pack_nibble({enc_bit, 1'b0, cnt[1:0]});
		end else begin
			pack_nibble({enc_bit, 1'b1, cnt[5:4]});
			pack_nibble(cnt[3:0]);
		end
	endfunction

	// expected code bytes for one accepted input transaction
	function automatic void encode_byte(input logic [7:0] data, input logic last);
		int k;
		for (k = 7; k >= 0; k--) begin
			if (data[k] == enc_bit) begin
				if (enc_len == MAX_CHUNK) begin
					pack_run(MAX_CHUNK);
					enc_len = 6'd1;
				end else begin
					enc_len = enc_len + 6'd1;
				end
			end else begin
				pack_run(enc_len);
				enc_bit = ~enc_bit;
				enc_len = 6'd1;
			end
		end
		if (last) begin
			pack_run(enc_len);
			if (enc_half)
				pack_nibble(4'h0);
			if (code_q.size() > 0)
				code_q[code_q.size() - 1].stream_end = 1'b1;
			enc_bit  = 1'b0;
			enc_len  = '0;
			enc_held = '0;
			enc_half = 1'b0;
		end
	endfunction

	function automatic void add_byte(input logic [7:0] data, input logic last, input bit drain);
		pending_byte_t p;
		p.data  = data;
		p.last  = last;
		p.drain = drain;
		byte_q.push_back(p);
	endfunction

	// directed corner streams, then random streams of mixed styles
	function automatic void build_streams();
		int            i;
		int            len;
		int            target;
		bit            drain;
		bit            drained;
		logic [7:0]    fill;
		logic [7:0]    b;
		stream_style_e style;
		// single-byte streams: all zeros, all ones, alternating bits
		add_byte(8'h00, 1'b1, 1'b0);
		add_byte(8'hFF, 1'b1, 1'b0);
		add_byte(8'hAA, 1'b1, 1'b0);
		add_byte(8'h55, 1'b1, 1'b0);
		// 72 zeros: a full 63-bit chunk then the rest on flush
		for (i = 0; i < 9; i++)
			add_byte(8'h00, i == 8, 1'b0);
		// 64 ones after an empty zero run
		for (i = 0; i < 8; i++)
			add_byte(8'hFF, i == 7, 1'b0);
		// short and long run boundaries
		add_byte(8'h1F, 1'b1, 1'b0);
		add_byte(8'h0F, 1'b1, 1'b0);
		add_byte(8'hE1, 1'b1, 1'b0);
		target  = byte_q.size() + RANDOM_LEN;
		drained = 1'b0;
		while (byte_q.size() < target) begin
			len   = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
			style = stream_style_e'($urandom_range(0, 3));
			drain = ($urandom_range(0, 15) == 0);
			if (!drained && byte_q.size() >= DRAIN_AT) begin
				drain   = 1'b1;
				drained = 1'b1;
			end
			fill = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			for (i = 0; i < len; i++) begin
				case (style)
					STY_LONG_RUN: begin
						b = fill;
						if ($urandom_range(0, 9) == 0)
							b[$urandom_range(0, 7)] = ~b[0];
					end
					STY_ALTERNATE: begin
						b = $urandom_range(0, 1) ? 8'hAA : 8'h55;
					end
					STY_SPARSE: begin
						b = 8'h00;
						if ($urandom_range(0, 3) == 0)
							b[$urandom_range(0, 7)] = 1'b1;
					end
					default: begin
						b = 8'($urandom_range(0, 255));
					end
				endcase
				add_byte(b, i == len - 1, drain && i == 0);
			end
		end
		total_bytes = byte_q.size();
	endfunction

	// random idling only outside quiet windows and the tail of the run
	function automatic bit gaps_allowed();
		return (byte_q.size() >= TAIL_ITEMS) && (((cycles >> 7) % 3) != 0);
	endfunction

	// cycle count and timeout
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// driver: offers pending bytes, holds a transaction while full
	always @(posedge clk) begin : drive_bytes
		pending_byte_t nxt;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				encode_byte(data_byte, final_byte);
				bytes_taken++;
			end
			if (!(push && full)) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (byte_q.size() == 0) begin
					push <= 1'b0;
				end else if (byte_q[0].drain && code_q.size() != 0 && hold_left == 0) begin
					push <= 1'b0;
				end else if (gaps_allowed() && $urandom_range(0, 5) == 0) begin
					gap_left = $urandom_range(0, 10);
					push <= 1'b0;
				end else begin
					nxt = byte_q.pop_front();
					push       <= 1'b1;
					data_byte  <= nxt.data;
					final_byte <= nxt.last;
				end
			end
		end
	end

	// monitor: checks each popped transaction and decides the next pop
	always @(posedge clk) begin : watch_codes
		brne_result_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (code_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected code byte %h stream_end %b", code_byte, stream_end);
				end else begin
					want = code_q.pop_front();
					if (code_byte !== want.code || stream_end !== want.stream_end) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("mismatch: code_byte exp %h got %h, stream_end exp %b got %b",
								want.code, code_byte, want.stream_end, stream_end);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (!held_off && bytes_taken >= HOLD_AFTER) begin
				// long hold-off so the block fills and stalls its input
				held_off  = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				pop <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (gaps_allowed() && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 10);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// stimulus setup, reset and end of run
	initial begin
		build_streams();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (bytes_taken < total_bytes)
			@(posedge clk);
		while (code_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && code_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
